FILE: src/esqf_pkg.sv
// ----------------------------------------------------------------------------
// esqf_pkg
// Shared types, constants and the fit microprogram of the encoder speed
// estimator.
// ----------------------------------------------------------------------------
package esqf_pkg;

   // ring of accepted pulse timestamps
   localparam int RING_DEPTH = 16;
   localparam int SLOT_W     = $clog2(RING_DEPTH);
   localparam int Y_W        = $clog2(RING_DEPTH + 1);

   // fit arithmetic runs modulo 2^128
   localparam int WIDE_W = 128;

   // scale factors
   localparam int unsigned TICKS_PER_S    = 1000;
   localparam int unsigned TICKS2_PER_S2X2 = 2000000;

   // request codes
   localparam logic [1:0] REQ_PULSE  = 2'd0;
   localparam logic [1:0] REQ_QUERY  = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // configuration registers
   localparam int         CSR_ADDR_W   = 3;
   localparam logic       CSR_DEBOUNCE = 1'b0;
   localparam logic       CSR_WINDOW   = 1'b1;
   localparam logic [15:0] DEBOUNCE_RESET = 16'd5;
   localparam logic [15:0] WINDOW_RESET   = 16'd1000;

   // register file of the fit unit
   localparam int NREGS = 19;
   localparam int RF_AW = 5;
   localparam logic [RF_AW-1:0] R_M1  = RF_AW'(0);
   localparam logic [RF_AW-1:0] R_M2  = RF_AW'(1);
   localparam logic [RF_AW-1:0] R_M3  = RF_AW'(2);
   localparam logic [RF_AW-1:0] R_M4  = RF_AW'(3);
   localparam logic [RF_AW-1:0] R_CNT = RF_AW'(4);
   localparam logic [RF_AW-1:0] R_Y0  = RF_AW'(5);
   localparam logic [RF_AW-1:0] R_Y1  = RF_AW'(6);
   localparam logic [RF_AW-1:0] R_Y2  = RF_AW'(7);
   localparam logic [RF_AW-1:0] R_C1  = RF_AW'(8);
   localparam logic [RF_AW-1:0] R_C2  = RF_AW'(9);
   localparam logic [RF_AW-1:0] R_C3  = RF_AW'(10);
   localparam logic [RF_AW-1:0] R_D   = RF_AW'(11);
   localparam logic [RF_AW-1:0] R_E1  = RF_AW'(12);
   localparam logic [RF_AW-1:0] R_E2  = RF_AW'(13);
   localparam logic [RF_AW-1:0] R_WA  = RF_AW'(14);
   localparam logic [RF_AW-1:0] R_WB  = RF_AW'(15);
   localparam logic [RF_AW-1:0] R_T0  = RF_AW'(16);
   localparam logic [RF_AW-1:0] R_T1  = RF_AW'(17);
   localparam logic [RF_AW-1:0] R_T2  = RF_AW'(18);

   // microprogram
   localparam int PC_W = 6;
   localparam logic [PC_W-1:0] PC_DET   = PC_W'(13);
   localparam logic [PC_W-1:0] PC_NUM_S = PC_W'(35);
   localparam logic [PC_W-1:0] PC_LAST  = PC_W'(36);

   // wide multiply: 32x32 partial products, truncated to 128 bits
   localparam logic [3:0] MUL_STEPS = 4'd10;

   typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL} op_type;
   typedef enum logic [1:0] {B_REG, B_WIN2, B_K1000, B_K2M} bsel_type;

   typedef struct packed {
      op_type           op;
      logic [RF_AW-1:0] dst;
      logic [RF_AW-1:0] a;
      logic [RF_AW-1:0] b;
      bsel_type         bsel;
   } uop_type;

   // limb pair {a limb, b limb} for partial product k
   function automatic logic [3:0] mul_pair(input logic [3:0] k);
      logic [3:0] p;
      unique case (k)
         4'd0:    p = {2'd0, 2'd0};
         4'd1:    p = {2'd0, 2'd1};
         4'd2:    p = {2'd1, 2'd0};
         4'd3:    p = {2'd0, 2'd2};
         4'd4:    p = {2'd1, 2'd1};
         4'd5:    p = {2'd2, 2'd0};
         4'd6:    p = {2'd0, 2'd3};
         4'd7:    p = {2'd1, 2'd2};
         4'd8:    p = {2'd2, 2'd1};
         4'd9:    p = {2'd3, 2'd0};
         default: p = 4'd0;
      endcase
      return p;
   endfunction

   // cramer determinants of the normal equations, then the scaled numerators
   function automatic uop_type prog_uop(input logic [PC_W-1:0] pc);
      uop_type u;
      unique case (pc)
         // denominator determinant
         6'd0:    u = '{OP_MUL, R_T0, R_M2, R_CNT, B_REG};
         6'd1:    u = '{OP_MUL, R_T1, R_M1, R_M1,  B_REG};
         6'd2:    u = '{OP_SUB, R_C1, R_T0, R_T1,  B_REG};
         6'd3:    u = '{OP_MUL, R_T0, R_M3, R_CNT, B_REG};
         6'd4:    u = '{OP_MUL, R_T1, R_M1, R_M2,  B_REG};
         6'd5:    u = '{OP_SUB, R_C2, R_T0, R_T1,  B_REG};
         6'd6:    u = '{OP_MUL, R_T0, R_M3, R_M1,  B_REG};
         6'd7:    u = '{OP_MUL, R_T1, R_M2, R_M2,  B_REG};
         6'd8:    u = '{OP_SUB, R_C3, R_T0, R_T1,  B_REG};
         6'd9:    u = '{OP_MUL, R_T0, R_M4, R_C1,  B_REG};
         6'd10:   u = '{OP_MUL, R_T1, R_M3, R_C2,  B_REG};
         6'd11:   u = '{OP_SUB, R_T0, R_T0, R_T1,  B_REG};
         6'd12:   u = '{OP_MUL, R_T1, R_M2, R_C3,  B_REG};
         6'd13:   u = '{OP_ADD, R_D,  R_T0, R_T1,  B_REG};
         // curvature determinant
         6'd14:   u = '{OP_MUL, R_T0, R_Y1, R_CNT, B_REG};
         6'd15:   u = '{OP_MUL, R_T1, R_M1, R_Y0,  B_REG};
         6'd16:   u = '{OP_SUB, R_E1, R_T0, R_T1,  B_REG};
         6'd17:   u = '{OP_MUL, R_T0, R_Y1, R_M1,  B_REG};
         6'd18:   u = '{OP_MUL, R_T1, R_M2, R_Y0,  B_REG};
         6'd19:   u = '{OP_SUB, R_E2, R_T0, R_T1,  B_REG};
         6'd20:   u = '{OP_MUL, R_T0, R_Y2, R_C1,  B_REG};
         6'd21:   u = '{OP_MUL, R_T1, R_M3, R_E1,  B_REG};
         6'd22:   u = '{OP_SUB, R_T0, R_T0, R_T1,  B_REG};
         6'd23:   u = '{OP_MUL, R_T1, R_M2, R_E2,  B_REG};
         6'd24:   u = '{OP_ADD, R_WA, R_T0, R_T1,  B_REG};
         // slope determinant
         6'd25:   u = '{OP_MUL, R_T0, R_M4, R_E1,  B_REG};
         6'd26:   u = '{OP_MUL, R_T1, R_Y2, R_C2,  B_REG};
         6'd27:   u = '{OP_SUB, R_T0, R_T0, R_T1,  B_REG};
         6'd28:   u = '{OP_MUL, R_T1, R_M3, R_Y0,  B_REG};
         6'd29:   u = '{OP_MUL, R_T2, R_Y1, R_M2,  B_REG};
         6'd30:   u = '{OP_SUB, R_T1, R_T1, R_T2,  B_REG};
         6'd31:   u = '{OP_MUL, R_T2, R_M2, R_T1,  B_REG};
         6'd32:   u = '{OP_ADD, R_WB, R_T0, R_T2,  B_REG};
         // slope at query time and scaling
         6'd33:   u = '{OP_MUL, R_T0, R_WA, R_WA,  B_WIN2};
         6'd34:   u = '{OP_ADD, R_T0, R_T0, R_WB,  B_REG};
         6'd35:   u = '{OP_MUL, R_T0, R_T0, R_T0,  B_K1000};
         6'd36:   u = '{OP_MUL, R_T1, R_WA, R_WA,  B_K2M};
         default: u = '{OP_ADD, R_T2, R_T2, R_T2,  B_REG};
      endcase
      return u;
   endfunction

endpackage

FILE: src/esqf_ifs.sv
// ----------------------------------------------------------------------------
// esqf channel interfaces
// Valid/ready channels for requests and query responses.
// ----------------------------------------------------------------------------
interface esqf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] timestamp;

   modport source (output valid, output req_type, output timestamp, input ready);
   modport sink   (input valid, input req_type, input timestamp, output ready);
endinterface

interface esqf_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        time_now;
   logic [31:0]        pulse_count;
   logic signed [31:0] speed;
   logic signed [31:0] accel;

   modport source (output valid, output time_now, output pulse_count, output speed,
                   output accel, input ready);
   modport sink   (input valid, input time_now, input pulse_count, input speed,
                   input accel, output ready);
endinterface

FILE: src/encoder_speed_quadratic_fit.sv
// ----------------------------------------------------------------------------
// encoder_speed_quadratic_fit
// Debounces timestamped encoder pulses, keeps the recent stamps in a ring
// and answers queries with count, speed and acceleration from a quadratic
// least squares fit.
// ----------------------------------------------------------------------------
// Usage
//   req_chan carries one transaction per event: pulse, query or clear, each
//   with its tick. Pulse and clear finish in the cycle they are accepted and
//   produce no response. A query produces one transaction on rsp_chan.
//   A query walks the ring newest first, one sample at a time. With three or
//   more it loads 8 moments into the fit register file, runs up to 37 add,
//   sub and 128-bit multiply microcode ops (multiplies on the one 32x32
//   multiplier) and two 128-step restoring divisions; with two samples or a
//   singular fit one division gives the speed from the two newest stamps.
//   req_chan.ready is high only while idle. The response sits in an output
//   register; while the receiver stalls a finished query waits in its result
//   state with req_chan.ready low, while pulses and clears are still taken
//   when only the output register is full. Reset (synchronous) empties the
//   ring, zeroes the pulse count and sets debounce to 5 and window to 1000
//   ticks. Registers are written over the APB port at byte addresses 0 and
//   4; the user writes them only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module encoder_speed_quadratic_fit (
   input  logic                            clock,
   input  logic                            reset,
   esqf_req_if.sink                        req_chan,
   esqf_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [esqf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import esqf_pkg::*;

   localparam int M1_W = 16 + Y_W;
   localparam int M2_W = 32 + Y_W;
   localparam int M3_W = 48 + Y_W;
   localparam int M4_W = 64 + Y_W;
   localparam int Y0_W = 2 * Y_W;
   localparam int Y1_W = 16 + 2 * Y_W;
   localparam int Y2_W = 32 + 2 * Y_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_WALK, ST_LOAD, ST_FETCH, ST_EXEC, ST_MUL, ST_CHECK,
      ST_DIV_START, ST_DIV_RUN, ST_DIV_END, ST_RESULT
   } state_type;

   state_type state_ff;

   // configuration
   logic [15:0] debounce_ff;
   logic [15:0] window_ff;

   // pulse record
   logic [31:0]           stamp_ring [RING_DEPTH];
   logic [RING_DEPTH-1:0] valid_ff;
   logic [SLOT_W-1:0]     write_slot_ff;
   logic                  have_stamp_ff;
   logic [31:0]           last_stamp_ff;
   logic [31:0]           pulse_total_ff;

   // walk
   logic [31:0]       now_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic [Y_W-1:0]    ycnt_ff;
   logic [Y_W-1:0]    cnt_ff;
   logic [2:0]        wph_ff;
   logic [15:0]       x_ff;
   logic [31:0]       x2_ff;
   logic [31:0]       s_new_ff;
   logic [31:0]       s_old_ff;
   logic [M1_W-1:0]   m1_ff;
   logic [M2_W-1:0]   m2_ff;
   logic [M3_W-1:0]   m3_ff;
   logic [M4_W-1:0]   m4_ff;
   logic [Y0_W-1:0]   y0_ff;
   logic [Y1_W-1:0]   y1_ff;
   logic [Y2_W-1:0]   y2_ff;

   // fit unit
   logic [WIDE_W-1:0] rf [NREGS];
   logic [WIDE_W-1:0] rd_a_ff;
   logic [WIDE_W-1:0] rd_b_ff;
   logic [PC_W-1:0]   pc_ff;
   logic [2:0]        lcnt_ff;
   logic [3:0]        mk_ff;
   logic [1:0]        sh_ff;
   logic [WIDE_W-1:0] acc_ff;
   logic [63:0]       prod_ff;
   logic [WIDE_W-1:0] den_ff;
   logic [WIDE_W-1:0] nums_ff;
   logic [WIDE_W-1:0] numa_ff;

   // divider
   logic              div_accel_ff;
   logic              two_div_ff;
   logic              neg_ff;
   logic [WIDE_W-1:0] q_ff;
   logic [WIDE_W-1:0] dd_ff;
   logic [WIDE_W-1:0] rem_ff;
   logic [6:0]        dcnt_ff;

   // results
   logic [31:0] speed_ff;
   logic [31:0] accel_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_time_ff;
   logic [31:0] rsp_count_ff;
   logic [31:0] rsp_speed_ff;
   logic [31:0] rsp_accel_ff;

   // ------------------------------------------------------------------------
   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         window_ff   <= WINDOW_RESET;
      end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
         unique case (paddr[CSR_ADDR_W-1:2])
            CSR_DEBOUNCE: debounce_ff <= pwdata[15:0];
            CSR_WINDOW:   window_ff   <= pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[CSR_ADDR_W-1:2])
         CSR_DEBOUNCE: prdata = {16'd0, debounce_ff};
         CSR_WINDOW:   prdata = {16'd0, window_ff};
      endcase
   end

   assign pready = 1'b1;

   // ------------------------------------------------------------------------
   // request decode
   logic req_fire;
   logic pulse_store;
   logic ring_we;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign pulse_store    = !have_stamp_ff ||
                           ({1'b0, req_chan.timestamp} > ({1'b0, last_stamp_ff} + 33'(debounce_ff)));
   assign ring_we        = req_fire && req_chan.req_type == REQ_PULSE && pulse_store;

   // timestamp ring
   always_ff @(posedge clock) begin
      if (ring_we) begin
         stamp_ring[write_slot_ff] <= req_chan.timestamp;
      end
   end

   // ------------------------------------------------------------------------
   // window walk checks
   logic [31:0]       s_cur;
   logic [32:0]       win_sum;
   logic              walk_go;
   logic [15:0]       x_in;
   logic [WIDE_W-1:0] lin_den;

   assign s_cur   = stamp_ring[idx_ff];
   assign win_sum = {1'b0, s_cur} + 33'(window_ff);
   assign walk_go = have_stamp_ff && ycnt_ff != '0 && valid_ff[idx_ff] &&
                    win_sum > {1'b0, now_ff} && s_cur <= now_ff;
   assign x_in    = 16'(win_sum - {1'b0, now_ff});
   assign lin_den = (s_new_ff > s_old_ff) ? WIDE_W'(s_new_ff - s_old_ff) : '0;

   // ------------------------------------------------------------------------
   // shared 32x32 multiplier
   uop_type           uop;
   logic [3:0]        pair;
   logic [WIDE_W-1:0] opb;
   logic [31:0]       mul_a;
   logic [31:0]       mul_b;

   assign uop  = prog_uop(pc_ff);
   assign pair = mul_pair(mk_ff);

   always_comb begin
      unique case (uop.bsel)
         B_REG:   opb = rd_b_ff;
         B_WIN2:  opb = WIDE_W'({window_ff, 1'b0});
         B_K1000: opb = WIDE_W'(TICKS_PER_S);
         B_K2M:   opb = WIDE_W'(TICKS2_PER_S2X2);
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_WALK) begin
         unique case (wph_ff)
            3'd1: begin mul_a = 32'(x_ff);    mul_b = 32'(x_ff);    end
            3'd2: begin mul_a = prod_ff[31:0]; mul_b = 32'(x_ff);    end
            3'd3: begin mul_a = x2_ff;        mul_b = x2_ff;        end
            3'd4: begin mul_a = 32'(x_ff);    mul_b = 32'(ycnt_ff); end
            3'd5: begin mul_a = x2_ff;        mul_b = 32'(ycnt_ff); end
            default: ;
         endcase
      end else if (state_ff == ST_MUL) begin
         mul_a = rd_a_ff[32*pair[3:2] +: 32];
         mul_b = opb[32*pair[1:0] +: 32];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      sh_ff   <= 2'(pair[3:2] + pair[1:0]);
   end

   // ------------------------------------------------------------------------
   // fit register file
   logic              rf_we;
   logic [RF_AW-1:0]  rf_waddr;
   logic [WIDE_W-1:0] rf_wdata;
   logic [WIDE_W-1:0] acc_in;
   logic [WIDE_W-1:0] alu_res;
   logic [WIDE_W-1:0] load_val;
   logic [RF_AW-1:0]  load_addr;
   logic              op_done;

   assign acc_in    = acc_ff + ((mk_ff != '0) ? (WIDE_W'(prod_ff) << {sh_ff, 5'd0}) : '0);
   assign alu_res   = (uop.op == OP_ADD) ? rd_a_ff + opb : rd_a_ff - opb;
   assign load_addr = RF_AW'(lcnt_ff);
   assign op_done   = (state_ff == ST_EXEC && uop.op != OP_MUL) ||
                      (state_ff == ST_MUL && mk_ff == MUL_STEPS);

   always_comb begin
      unique case (load_addr)
         R_M1:    load_val = WIDE_W'(m1_ff);
         R_M2:    load_val = WIDE_W'(m2_ff);
         R_M3:    load_val = WIDE_W'(m3_ff);
         R_M4:    load_val = WIDE_W'(m4_ff);
         R_CNT:   load_val = WIDE_W'(cnt_ff);
         R_Y0:    load_val = WIDE_W'(y0_ff);
         R_Y1:    load_val = WIDE_W'(y1_ff);
         R_Y2:    load_val = WIDE_W'(y2_ff);
         default: load_val = '0;
      endcase
   end

   always_comb begin
      rf_we    = (state_ff == ST_LOAD) || op_done;
      rf_waddr = (state_ff == ST_LOAD) ? load_addr : uop.dst;
      if (state_ff == ST_LOAD) begin
         rf_wdata = load_val;
      end else if (state_ff == ST_EXEC) begin
         rf_wdata = alu_res;
      end else begin
         rf_wdata = acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf[rf_waddr] <= rf_wdata;
      end
      rd_a_ff <= rf[uop.a];
      rd_b_ff <= rf[uop.b];
   end

   // ------------------------------------------------------------------------
   // divider helpers
   logic [WIDE_W-1:0] div_num;
   logic [WIDE_W-1:0] r_sh;
   logic [31:0]       sat_res;

   assign div_num = div_accel_ff ? numa_ff : nums_ff;
   assign r_sh    = {rem_ff[WIDE_W-2:0], q_ff[WIDE_W-1]};

   always_comb begin
      if (!neg_ff) begin
         sat_res = (q_ff[WIDE_W-1:31] != '0) ? 32'h7fff_ffff : q_ff[31:0];
      end else begin
         sat_res = (q_ff > WIDE_W'(32'h8000_0000)) ? 32'h8000_0000 : 32'(32'd0 - q_ff[31:0]);
      end
   end

   // ------------------------------------------------------------------------
   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pulse_total_ff <= '0;
         valid_ff       <= '0;
         write_slot_ff  <= '0;
         have_stamp_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // output register empties on acceptance unless refilled below
         if (rsp_chan.valid && rsp_chan.ready && state_ff != ST_RESULT) begin
            rsp_valid_ff <= 1'b0;
         end

         // capture determinant and numerators as they are written
         if (op_done) begin
            if (pc_ff == PC_DET) begin
               den_ff <= rf_wdata;
            end
            if (pc_ff == PC_NUM_S) begin
               nums_ff <= rf_wdata;
            end
            if (pc_ff == PC_LAST) begin
               numa_ff <= rf_wdata;
            end
            pc_ff <= pc_ff + 1'b1;
            if (pc_ff == PC_DET) begin
               state_ff <= ST_CHECK;
            end else if (pc_ff == PC_LAST) begin
               div_accel_ff <= 1'b0;
               two_div_ff   <= 1'b1;
               state_ff     <= ST_DIV_START;
            end else begin
               state_ff <= ST_FETCH;
            end
         end

         unique case (state_ff)
            // take a transaction
            ST_IDLE: begin
               if (req_fire) begin
                  case (req_chan.req_type)
                     REQ_PULSE: begin
                        if (pulse_store) begin
                           pulse_total_ff          <= pulse_total_ff + 1'b1;
                           valid_ff[write_slot_ff] <= 1'b1;
                           write_slot_ff <= (write_slot_ff == SLOT_W'(RING_DEPTH - 1)) ?
                                            '0 : write_slot_ff + 1'b1;
                           have_stamp_ff <= 1'b1;
                           last_stamp_ff <= req_chan.timestamp;
                        end
                     end
                     REQ_CLEAR: begin
                        valid_ff      <= '0;
                        write_slot_ff <= '0;
                        have_stamp_ff <= 1'b0;
                     end
                     REQ_QUERY: begin
                        now_ff   <= req_chan.timestamp;
                        idx_ff   <= (write_slot_ff == '0) ?
                                    SLOT_W'(RING_DEPTH - 1) : write_slot_ff - 1'b1;
                        ycnt_ff  <= Y_W'(RING_DEPTH);
                        cnt_ff   <= '0;
                        wph_ff   <= '0;
                        m1_ff    <= '0;
                        m2_ff    <= '0;
                        m3_ff    <= '0;
                        m4_ff    <= '0;
                        y0_ff    <= '0;
                        y1_ff    <= '0;
                        y2_ff    <= '0;
                        speed_ff <= '0;
                        accel_ff <= '0;
                        state_ff <= ST_WALK;
                     end
                     default: ;
                  endcase
               end
            end

            // accumulate moments, one sample at a time
            ST_WALK: begin
               unique case (wph_ff)
                  3'd0: begin
                     if (walk_go) begin
                        x_ff <= x_in;
                        if (cnt_ff == Y_W'(0)) begin
                           s_new_ff <= s_cur;
                        end
                        if (cnt_ff == Y_W'(1)) begin
                           s_old_ff <= s_cur;
                        end
                        cnt_ff <= cnt_ff + 1'b1;
                        m1_ff  <= m1_ff + M1_W'(x_in);
                        y0_ff  <= y0_ff + Y0_W'(ycnt_ff);
                        wph_ff <= 3'd1;
                     end else if (cnt_ff < Y_W'(2)) begin
                        state_ff <= ST_RESULT;
                     end else if (cnt_ff == Y_W'(2)) begin
                        nums_ff      <= WIDE_W'(TICKS_PER_S);
                        den_ff       <= lin_den;
                        div_accel_ff <= 1'b0;
                        two_div_ff   <= 1'b0;
                        state_ff     <= ST_DIV_START;
                     end else begin
                        lcnt_ff  <= '0;
                        state_ff <= ST_LOAD;
                     end
                  end
                  3'd1: wph_ff <= 3'd2;
                  3'd2: begin
                     x2_ff  <= prod_ff[31:0];
                     m2_ff  <= m2_ff + M2_W'(prod_ff);
                     wph_ff <= 3'd3;
                  end
                  3'd3: begin
                     m3_ff  <= m3_ff + M3_W'(prod_ff);
                     wph_ff <= 3'd4;
                  end
                  3'd4: begin
                     m4_ff  <= m4_ff + M4_W'(prod_ff);
                     wph_ff <= 3'd5;
                  end
                  3'd5: begin
                     y1_ff  <= y1_ff + Y1_W'(prod_ff);
                     wph_ff <= 3'd6;
                  end
                  3'd6: begin
                     y2_ff   <= y2_ff + Y2_W'(prod_ff);
                     idx_ff  <= (idx_ff == '0) ? SLOT_W'(RING_DEPTH - 1) : idx_ff - 1'b1;
                     ycnt_ff <= ycnt_ff - 1'b1;
                     wph_ff  <= 3'd0;
                  end
                  default: wph_ff <= 3'd0;
               endcase
            end

            // moments into the register file
            ST_LOAD: begin
               lcnt_ff <= lcnt_ff + 1'b1;
               if (lcnt_ff == 3'd7) begin
                  pc_ff    <= '0;
                  state_ff <= ST_FETCH;
               end
            end

            ST_FETCH: state_ff <= ST_EXEC;

            ST_EXEC: begin
               if (uop.op == OP_MUL) begin
                  mk_ff    <= '0;
                  acc_ff   <= '0;
                  state_ff <= ST_MUL;
               end
            end

            ST_MUL: begin
               mk_ff  <= mk_ff + 1'b1;
               acc_ff <= acc_in;
            end

            // singular system falls back to the two newest stamps
            ST_CHECK: begin
               if (den_ff == '0) begin
                  nums_ff      <= WIDE_W'(TICKS_PER_S);
                  den_ff       <= lin_den;
                  div_accel_ff <= 1'b0;
                  two_div_ff   <= 1'b0;
                  state_ff     <= ST_DIV_START;
               end else begin
                  state_ff <= ST_FETCH;
               end
            end

            ST_DIV_START: begin
               if (den_ff == '0) begin
                  q_ff     <= '0;
                  neg_ff   <= 1'b0;
                  state_ff <= ST_DIV_END;
               end else begin
                  neg_ff   <= div_num[WIDE_W-1] ^ den_ff[WIDE_W-1];
                  q_ff     <= div_num[WIDE_W-1] ? '0 - div_num : div_num;
                  dd_ff    <= den_ff[WIDE_W-1] ? '0 - den_ff : den_ff;
                  rem_ff   <= '0;
                  dcnt_ff  <= '0;
                  state_ff <= ST_DIV_RUN;
               end
            end

            // restoring division, one quotient bit per cycle
            ST_DIV_RUN: begin
               if (r_sh >= dd_ff) begin
                  rem_ff <= r_sh - dd_ff;
                  q_ff   <= {q_ff[WIDE_W-2:0], 1'b1};
               end else begin
                  rem_ff <= r_sh;
                  q_ff   <= {q_ff[WIDE_W-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == 7'd127) begin
                  state_ff <= ST_DIV_END;
               end
            end

            ST_DIV_END: begin
               if (div_accel_ff) begin
                  accel_ff <= sat_res;
               end else begin
                  speed_ff <= sat_res;
               end
               if (two_div_ff && !div_accel_ff) begin
                  div_accel_ff <= 1'b1;
                  state_ff     <= ST_DIV_START;
               end else begin
                  state_ff <= ST_RESULT;
               end
            end

            // hand the response to the output register
            ST_RESULT: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_time_ff  <= now_ff;
                  rsp_count_ff <= pulse_total_ff;
                  rsp_speed_ff <= speed_ff;
                  rsp_accel_ff <= accel_ff;
                  state_ff     <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.time_now    = rsp_time_ff;
   assign rsp_chan.pulse_count = rsp_count_ff;
   assign rsp_chan.speed       = rsp_speed_ff;
   assign rsp_chan.accel       = rsp_accel_ff;

   // ------------------------------------------------------------------------
   // checks
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.req_type == REQ_CLEAR) |=>
         (valid_ff == '0 && !have_stamp_ff && write_slot_ff == '0))
      else $error("clear left ring state behind");

   a_store_marks_valid: assert property (@(posedge clock) disable iff (reset)
      ring_we |=> (valid_ff[$past(write_slot_ff)] && have_stamp_ff))
      else $error("stored pulse not marked valid");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (cnt_ff <= Y_W'(RING_DEPTH)))
      else $error("walk took more samples than the ring holds");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_RUN) |-> (dd_ff != '0))
      else $error("division running on zero divisor");

   a_mul_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (mk_ff <= MUL_STEPS))
      else $error("wide multiply overran its partial products");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESULT))
      else $error("response raised outside result state");

endmodule
